FILE: hdl/bclp_pkg.sv
// Package: shared types and codes for the button click / long-press detector.
`default_nettype none
package bclp_pkg;

  // Threshold register width, fixed by the register map
  localparam int unsigned THR_W  = 16;
  localparam int unsigned IDX_W  = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PRESS_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_DOUBLE_CLICK = 3'd3;
  localparam logic [IDX_W-1:0] REG_REPEAT       = 3'd4;

  // Reset values of the registers
  localparam logic [THR_W-1:0] RST_DEBOUNCE     = 16'd1;
  localparam logic [THR_W-1:0] RST_LONG_PRESS   = 16'd50;
  localparam logic [THR_W-1:0] RST_DOUBLE_CLICK = 16'd15;
  localparam logic [THR_W-1:0] RST_REPEAT       = 16'd5;

  typedef enum logic [2:0] {
    ST_RELEASED = 3'd0,
    ST_DEBOUNCE = 3'd1,
    ST_PRESSED  = 3'd2,
    ST_LONG     = 3'd3,
    ST_WAIT     = 3'd4
  } state_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_SHORT  = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_LONG   = 3'd4,
    EV_REPEAT = 3'd5
  } event_t;

  typedef struct packed {
    logic             press_level;
    logic [THR_W-1:0] debounce_ticks;
    logic [THR_W-1:0] long_press_ticks;
    logic [THR_W-1:0] double_click_ticks;
    logic [THR_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic   is_long_pressed;
    logic   is_pressed;
    event_t event_code;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/bclp_cfg.sv
// Configuration register bank for the button detector.
`default_nettype none
module bclp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [bclp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [bclp_pkg::THR_W-1:0]   cfg_data,
  output bclp_pkg::cfg_t                    cfg
);
  import bclp_pkg::*;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level        <= 1'b0;
      cfg.debounce_ticks     <= RST_DEBOUNCE;
      cfg.long_press_ticks   <= RST_LONG_PRESS;
      cfg.double_click_ticks <= RST_DOUBLE_CLICK;
      cfg.repeat_ticks       <= RST_REPEAT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRESS_LEVEL:  cfg.press_level        <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ticks     <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ticks   <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ticks <= cfg_data;
        REG_REPEAT:       cfg.repeat_ticks       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bclp_fsm.sv
// Button state machine: debounce, click counting, long press and repeat.
`default_nettype none
module bclp_fsm #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic        raw_level,
  input  bclp_pkg::cfg_t   cfg,
  output bclp_pkg::result_t res
);
  import bclp_pkg::*;

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (CW > THR_W) ? CW : THR_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  state_t        state, state_next;
  logic [CW-1:0] hold_counter, hold_counter_next;
  logic [CW-1:0] release_counter, release_counter_next;
  logic [CW-1:0] repeat_counter, repeat_counter_next;
  logic [1:0]    click_counter, click_counter_next;
  logic          long_fired, long_fired_next;
  event_t        ev;

  logic          act;
  logic [CW-1:0] hold_inc, release_inc, repeat_inc;
  logic          hold_ge_deb, hold_inc_ge_long, hold_lt_long;
  logic          rel_inc_ge_dbl, rep_inc_ge_rpt;

  // Saturating increments and threshold compares, widened to a common width
  always_comb begin
    act              = (raw_level == cfg.press_level);
    hold_inc         = (hold_counter == CNT_MAX) ? CNT_MAX : hold_counter + 1'b1;
    release_inc      = (release_counter == CNT_MAX) ? CNT_MAX : release_counter + 1'b1;
    repeat_inc       = (repeat_counter == CNT_MAX) ? CNT_MAX : repeat_counter + 1'b1;
    hold_ge_deb      = CMP_W'(hold_inc) >= CMP_W'(cfg.debounce_ticks);
    hold_inc_ge_long = CMP_W'(hold_inc) >= CMP_W'(cfg.long_press_ticks);
    hold_lt_long     = CMP_W'(hold_counter) < CMP_W'(cfg.long_press_ticks);
    rel_inc_ge_dbl   = CMP_W'(release_inc) >= CMP_W'(cfg.double_click_ticks);
    rep_inc_ge_rpt   = CMP_W'(repeat_inc) >= CMP_W'(cfg.repeat_ticks);
  end

  // Next state and event
  always_comb begin
    state_next           = state;
    hold_counter_next    = hold_counter;
    release_counter_next = release_counter;
    repeat_counter_next  = repeat_counter;
    click_counter_next   = click_counter;
    long_fired_next      = long_fired;
    ev                   = EV_NONE;
    case (state)
      ST_DEBOUNCE: begin
        if (act) begin
          hold_counter_next = hold_inc;
          if (hold_ge_deb) begin
            state_next        = ST_PRESSED;
            ev                = EV_PRESS;
            hold_counter_next = '0;
            if (click_counter != 2'd3) begin
              click_counter_next = click_counter + 2'd1;
            end
          end
        end else begin
          state_next = ST_RELEASED;
        end
      end
      ST_PRESSED: begin
        if (!act) begin
          state_next           = ST_DEBOUNCE;
          release_counter_next = '0;
          hold_counter_next    = '0;
          long_fired_next      = 1'b0;
          if (hold_lt_long) begin
            if (click_counter == 2'd1) begin
              state_next = ST_WAIT;
            end else if (click_counter >= 2'd2) begin
              ev                 = EV_DOUBLE;
              click_counter_next = 2'd0;
              state_next         = ST_RELEASED;
            end
          end else begin
            ev                 = EV_SHORT;
            click_counter_next = 2'd0;
          end
        end else begin
          hold_counter_next = hold_inc;
          if (hold_inc_ge_long && !long_fired) begin
            ev                  = EV_LONG;
            long_fired_next     = 1'b1;
            state_next          = ST_LONG;
            repeat_counter_next = '0;
            click_counter_next  = 2'd0;
          end
        end
      end
      ST_LONG: begin
        if (!act) begin
          state_next        = ST_DEBOUNCE;
          long_fired_next   = 1'b0;
          hold_counter_next = '0;
        end else begin
          repeat_counter_next = repeat_inc;
          if ((cfg.repeat_ticks != '0) && rep_inc_ge_rpt) begin
            ev                  = EV_REPEAT;
            repeat_counter_next = '0;
          end
        end
      end
      ST_WAIT: begin
        if (act) begin
          state_next           = ST_DEBOUNCE;
          hold_counter_next    = '0;
          release_counter_next = '0;
        end else begin
          release_counter_next = release_inc;
          if (rel_inc_ge_dbl) begin
            if (click_counter == 2'd1) begin
              ev = EV_SHORT;
            end
            state_next         = ST_RELEASED;
            click_counter_next = 2'd0;
          end
        end
      end
      default: begin
        // released, and any stray code
        if (act) begin
          state_next          = ST_DEBOUNCE;
          hold_counter_next   = '0;
          long_fired_next     = 1'b0;
          repeat_counter_next = '0;
        end
        release_counter_next = '0;
      end
    endcase
    res.event_code      = ev;
    res.is_pressed      = (state_next == ST_PRESSED) || (state_next == ST_LONG);
    res.is_long_pressed = (state_next == ST_LONG);
  end

  // State registers advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_RELEASED;
      hold_counter    <= '0;
      release_counter <= '0;
      repeat_counter  <= '0;
      click_counter   <= 2'd0;
      long_fired      <= 1'b0;
    end else if (take) begin
      state           <= state_next;
      hold_counter    <= hold_counter_next;
      release_counter <= release_counter_next;
      repeat_counter  <= repeat_counter_next;
      click_counter   <= click_counter_next;
      long_fired      <= long_fired_next;
    end
  end

  // Long press lands in the long state with the fired flag set
  a_long_entry: assert property (@(posedge clk) disable iff (rst)
    take && (ev == EV_LONG) |=> (state == ST_LONG) && long_fired)
    else $error("long press did not enter long state");

  // Repeat restarts the interval count
  a_repeat_clear: assert property (@(posedge clk) disable iff (rst)
    take && (ev == EV_REPEAT) |=> (repeat_counter == '0))
    else $error("repeat counter not cleared");

  // Waiting for a second click only with exactly one click counted
  a_wait_click: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> (click_counter == 2'd1))
    else $error("wait state with wrong click count");

  // Long state always carries the fired flag
  a_long_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LONG) |-> long_fired)
    else $error("long state without fired flag");

endmodule
`default_nettype wire

FILE: hdl/bclp_out.sv
// Result register between the state machine and the output stream.
`default_nettype none
module bclp_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  bclp_pkg::result_t  res_in,
  output logic               can_load,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata
);
  import bclp_pkg::*;

  result_t res_q;

  // Free when empty or being drained this cycle
  assign can_load = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_q <= res_in;
    end
  end

  assign m_tdata = {3'b000, res_q.is_long_pressed, res_q.is_pressed, res_q.event_code};

endmodule
`default_nettype wire

FILE: hdl/button_click_long_press_fsm.sv
// Top level of the button debounce, click and long-press detector.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata[0] raw_level
//  m_*      out  m_tvalid/m_tready   m_tdata[2:0] event, [3] pressed, [4] long pressed
//  cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One tick request per cycle while s_tready is high; its result appears in the cycle after acceptance.
// State update and result are computed in one pass and land in the result register.
// A stalled output holds s_tready low only while the result register is full.
// Reset puts the machine in the released state and loads register defaults.
`default_nettype none
module button_click_long_press_fsm #(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // [0] raw_level
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // [2:0] event_code, [3] is_pressed,
                                                      // [4] is_long_pressed
  input  wire logic                        cfg_we,
  input  wire logic [bclp_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [bclp_pkg::THR_W-1:0]  cfg_data
);
  import bclp_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    can_load;
  logic    take;

  assign s_tready = can_load;
  assign take     = s_tvalid && can_load;

  bclp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bclp_fsm #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .raw_level (s_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  bclp_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res_in   (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire
